// ----- design/sbe_pkg.sv -----
// ----------------------------------------------------------------------------
// sbe_pkg
// Shared types, codes and default sizes for the stack bytecode executor.
// ----------------------------------------------------------------------------
package sbe_pkg;

    localparam int DEF_DATA_STACK_DEPTH   = 256;
    localparam int DEF_MEMORY_WORDS       = 1024;
    localparam int DEF_RETURN_STACK_DEPTH = 256;
    localparam int DEF_PC_BITS            = 16;

    localparam int OP_W     = 5;
    localparam int WORD_W   = 32;
    localparam int CLEN_W   = 16;
    localparam int STATUS_W = 4;
    localparam int OUT_W    = 64;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 5'd0,
        OP_POP   = 5'd1,
        OP_DUP   = 5'd2,
        OP_HALT  = 5'd3,
        OP_ADD   = 5'd4,
        OP_SUB   = 5'd5,
        OP_MUL   = 5'd6,
        OP_DIV   = 5'd7,
        OP_CMP   = 5'd8,
        OP_STW   = 5'd9,
        OP_LOAD  = 5'd10,
        OP_JMP   = 5'd11,
        OP_JZ    = 5'd12,
        OP_JNZ   = 5'd13,
        OP_CALL  = 5'd14,
        OP_RET   = 5'd15
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK         = 4'd0,
        STS_HALTED     = 4'd1,
        STS_UNDERFLOW  = 4'd2,
        STS_OVERFLOW   = 4'd3,
        STS_DIV_ZERO   = 4'd4,
        STS_LOAD_FAULT = 4'd5,
        STS_STORE_FAULT= 4'd6,
        STS_CALL_OVF   = 4'd7,
        STS_CALL_UNF   = 4'd8,
        STS_BAD_OP     = 4'd9,
        STS_END        = 4'd10,
        STS_STOPPED    = 4'd11
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIVW,
        ST_WR2,
        ST_REFILL,
        ST_FINISH
    } state_t;

endpackage

// ----- design/sbe_ram.sv -----
// ----------------------------------------------------------------------------
// sbe_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/sbe_div.sv -----
// ----------------------------------------------------------------------------
// sbe_div
// Signed 32-bit divider, truncating; restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sbe_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic [32:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic        neg_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [32:0] rem_shift;
    logic [32:0] diff;

    assign rem_shift = {rem_reg[31:0], quo_reg[31]};
    assign diff      = rem_shift - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= dividend[31] ? (32'd0 - dividend) : dividend;
                dvs_reg  <= divisor[31] ? (32'd0 - divisor) : divisor;
                neg_reg  <= dividend[31] ^ divisor[31];
            end else if (busy_reg) begin
                if (!diff[32]) begin
                    rem_reg <= diff;
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end else begin
                    rem_reg <= rem_shift;
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (32'd0 - quo_reg) : quo_reg;

endmodule

// ----- design/stack_bytecode_executor_top.sv -----
// ----------------------------------------------------------------------------
// stack_bytecode_executor_top
// Executes one decoded stack-machine instruction per input beat.
// ----------------------------------------------------------------------------
// One input beat carries one decoded instruction (opcode in s_tuser, immediate
// in s_tdata); one output beat reports pc, top of stack, depth, running flag
// and status after it. Data stack, return stack and word memory each live in
// a RAM with a registered read. On accept the RAMs are addressed with the
// second-from-top slot, the immediate and the top return slot; the next cycle
// executes and writes back, then a finish state registers the result and can
// already take the next beat once the output is free. dup on an empty stack and
// div by zero with entries left below add a state (a second write or a
// refill read of the top of stack); div waits on the divider, which makes
// one quotient bit per cycle. Top of stack is cached in a register so results
// need no extra read. code_length is written through cfg_wr_en / cfg_wr_data;
// the user must write it only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module stack_bytecode_executor_top #(
    parameter int DATA_STACK_DEPTH   = sbe_pkg::DEF_DATA_STACK_DEPTH,
    parameter int MEMORY_WORDS       = sbe_pkg::DEF_MEMORY_WORDS,
    parameter int RETURN_STACK_DEPTH = sbe_pkg::DEF_RETURN_STACK_DEPTH,
    parameter int PC_BITS            = sbe_pkg::DEF_PC_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // config
    input  logic                        cfg_wr_en,
    input  logic [sbe_pkg::CLEN_W-1:0]  cfg_wr_data,    // code_length
    // instruction stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [sbe_pkg::WORD_W-1:0]  s_tdata,        // [31:0] immediate
    input  logic [sbe_pkg::OP_W-1:0]    s_tuser,        // [4:0] operation
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [15:0] next_pc, [47:16] top_value, [56:48] stack_depth,
    // [57] still_running, [61:58] status, [63:62] zero
    output logic [sbe_pkg::OUT_W-1:0]   m_tdata
);
    import sbe_pkg::*;

    localparam int SPW   = $clog2(DATA_STACK_DEPTH + 1);
    localparam int DS_AW = $clog2(DATA_STACK_DEPTH);
    localparam int RPW   = $clog2(RETURN_STACK_DEPTH + 1);
    localparam int RS_AW = (RETURN_STACK_DEPTH > 1) ? $clog2(RETURN_STACK_DEPTH) : 1;
    localparam int WM_AW = (MEMORY_WORDS > 1) ? $clog2(MEMORY_WORDS) : 1;

    // architectural state
    state_t               state_reg, state_next;
    logic [SPW-1:0]       sp_reg, sp_next;
    logic [RPW-1:0]       rp_reg, rp_next;
    logic [PC_BITS-1:0]   pc_reg, pc_next;
    logic                 run_reg, run_next;
    logic [31:0]          tos_reg, tos_next;
    status_t              status_reg, status_next;
    logic [CLEN_W-1:0]    clen_reg;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [31:0]          imm_reg, imm_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]     m_tdata_reg, m_tdata_next;

    // RAM ports
    logic                 ds_we, rs_we, wm_we;
    logic [DS_AW-1:0]     ds_waddr, ds_raddr;
    logic [31:0]          ds_wdata, ds_rdata;
    logic [RS_AW-1:0]     rs_waddr, rs_raddr;
    logic [PC_BITS-1:0]   rs_wdata, rs_rdata;
    logic [WM_AW-1:0]     wm_waddr, wm_raddr;
    logic [31:0]          wm_wdata, wm_rdata;

    logic                 div_start, div_done;
    logic [31:0]          div_q;
    logic [31:0]          div_a, div_b;

    // address helpers
    logic [SPW-1:0]       sp_m2, sp_m3;
    logic [RPW-1:0]       rp_m1;
    logic [31:0]          pc32, clen32, sp32;
    logic                 out_free, accept;

    assign sp_m2    = sp_reg - SPW'(2);
    assign sp_m3    = sp_reg - SPW'(3);
    assign rp_m1    = rp_reg - RPW'(1);
    assign pc32     = 32'(pc_reg);
    assign clen32   = 32'(clen_reg);
    assign sp32     = 32'(sp_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) || ((state_reg == ST_FINISH) && out_free);
    assign accept   = s_tvalid && s_tready;

    // Read addresses: second-from-top on accept, third-from-top during execute
    // (refill after a double pop with nothing pushed back).
    assign ds_raddr = (state_reg == ST_EXEC) ? sp_m3[DS_AW-1:0] : sp_m2[DS_AW-1:0];
    assign rs_raddr = rp_m1[RS_AW-1:0];
    assign wm_raddr = s_tdata[WM_AW-1:0];

    // popped operands: b is the top, a the one below; a failed pop gives 0
    assign div_a = (sp_reg >= SPW'(2)) ? ds_rdata : 32'd0;
    assign div_b = (sp_reg != '0) ? tos_reg : 32'd0;

    sbe_ram #(.WIDTH(32), .DEPTH(DATA_STACK_DEPTH), .AW(DS_AW)) u_ds_ram (
        .aclk(aclk), .we(ds_we), .waddr(ds_waddr), .wdata(ds_wdata),
        .raddr(ds_raddr), .rdata(ds_rdata)
    );

    sbe_ram #(.WIDTH(PC_BITS), .DEPTH(RETURN_STACK_DEPTH), .AW(RS_AW)) u_rs_ram (
        .aclk(aclk), .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
        .raddr(rs_raddr), .rdata(rs_rdata)
    );

    sbe_ram #(.WIDTH(32), .DEPTH(MEMORY_WORDS), .AW(WM_AW)) u_wm_ram (
        .aclk(aclk), .we(wm_we), .waddr(wm_waddr), .wdata(wm_wdata),
        .raddr(wm_raddr), .rdata(wm_rdata)
    );

    sbe_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(div_a), .divisor(div_b),
        .done(div_done), .quotient(div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            sp_reg       <= '0;
            rp_reg       <= '0;
            pc_reg       <= '0;
            run_reg      <= 1'b1;
            clen_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sp_reg       <= sp_next;
            rp_reg       <= rp_next;
            pc_reg       <= pc_next;
            run_reg      <= run_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                clen_reg <= cfg_wr_data;
            end
        end
        tos_reg     <= tos_next;
        status_reg  <= status_next;
        op_reg      <= op_next;
        imm_reg     <= imm_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb begin
        logic              sp_ge1, sp_ge2, sp_full, addr_ok, halted;
        logic [31:0]       a_val, b_val, res, ld_val;
        logic [SPW-1:0]    sp1, sp2;
        logic [PC_BITS-1:0] pc_inc, pc_imm, jmp_t;
        status_t           err;
        logic [31:0]       top_out;

        state_next    = state_reg;
        sp_next       = sp_reg;
        rp_next       = rp_reg;
        pc_next       = pc_reg;
        run_next      = run_reg;
        tos_next      = tos_reg;
        status_next   = status_reg;
        op_next       = op_reg;
        imm_next      = imm_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        ds_we = 1'b0; ds_waddr = sp_reg[DS_AW-1:0]; ds_wdata = 32'd0;
        rs_we = 1'b0; rs_waddr = rp_reg[RS_AW-1:0];
        wm_we = 1'b0; wm_waddr = imm_reg[WM_AW-1:0]; wm_wdata = 32'd0;
        div_start = 1'b0;

        sp_ge1  = (sp_reg != '0);
        sp_ge2  = (sp_reg >= SPW'(2));
        sp_full = (sp_reg == SPW'(DATA_STACK_DEPTH));
        b_val   = sp_ge1 ? tos_reg : 32'd0;
        a_val   = sp_ge2 ? ds_rdata : 32'd0;
        sp1     = sp_ge1 ? sp_reg - SPW'(1) : '0;
        sp2     = sp_ge2 ? sp_m2 : '0;
        pc_inc  = pc_reg + PC_BITS'(1);
        pc_imm  = pc_reg + PC_BITS'(5);
        jmp_t   = imm_reg[PC_BITS-1:0];
        addr_ok = !imm_reg[31] && (imm_reg < 32'(MEMORY_WORDS));
        ld_val  = addr_ok ? wm_rdata : 32'd0;
        rs_wdata = pc_imm;
        res     = 32'd0;
        err     = STS_OK;
        halted  = 1'b0;
        top_out = sp_ge1 ? tos_reg : 32'd0;

        unique case (state_reg)
            ST_IDLE: begin
                // waits for a beat; a pending result may still sit on m_
            end
            ST_EXEC: begin
                state_next = ST_FINISH;
                if (!run_reg) begin
                    status_next = STS_STOPPED;
                end else if (pc32 >= clen32) begin
                    run_next    = 1'b0;
                    status_next = STS_END;
                end else begin
                    pc_next = pc_inc;
                    unique case (op_reg)
                        OP_PUSH: begin
                            pc_next = pc_imm;
                            if (sp_full) begin
                                err = STS_OVERFLOW;
                            end else begin
                                ds_we = 1'b1; ds_wdata = imm_reg;
                                sp_next = sp_reg + SPW'(1); tos_next = imm_reg;
                            end
                        end
                        OP_POP: begin
                            if (!sp_ge1) err = STS_UNDERFLOW;
                            sp_next = sp1; tos_next = ds_rdata;
                        end
                        OP_DUP: begin
                            if (!sp_ge1) begin
                                // empty: two zeros go in, second one next cycle
                                err = STS_UNDERFLOW;
                                ds_we = 1'b1; ds_waddr = '0; ds_wdata = 32'd0;
                                sp_next = SPW'(1); tos_next = 32'd0;
                                state_next = ST_WR2;
                            end else if (sp_full) begin
                                err = STS_OVERFLOW;
                            end else begin
                                ds_we = 1'b1; ds_wdata = tos_reg;
                                sp_next = sp_reg + SPW'(1);
                            end
                        end
                        OP_HALT: begin
                            run_next = 1'b0; halted = 1'b1;
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_CMP: begin
                            if (!sp_ge2) err = STS_UNDERFLOW;
                            priority case (op_reg)
                                OP_ADD:  res = a_val + b_val;
                                OP_SUB:  res = a_val - b_val;
                                OP_MUL:  res = a_val * b_val;
                                default: res = {31'd0, $signed(a_val) < $signed(b_val)};
                            endcase
                            ds_we = 1'b1; ds_waddr = sp2[DS_AW-1:0]; ds_wdata = res;
                            sp_next = sp2 + SPW'(1); tos_next = res;
                        end
                        OP_DIV: begin
                            if (!sp_ge2) err = STS_UNDERFLOW;
                            sp_next = sp2;
                            if (b_val == 32'd0) begin
                                if (err == STS_OK) err = STS_DIV_ZERO;
                                if (sp2 != '0) state_next = ST_REFILL;
                            end else begin
                                div_start  = 1'b1;
                                state_next = ST_DIVW;
                            end
                        end
                        OP_STW: begin
                            pc_next = pc_imm;
                            if (!sp_ge1) err = STS_UNDERFLOW;
                            sp_next = sp1; tos_next = ds_rdata;
                            if (addr_ok) begin
                                wm_we = 1'b1; wm_wdata = b_val;
                            end else if (err == STS_OK) begin
                                err = STS_STORE_FAULT;
                            end
                        end
                        OP_LOAD: begin
                            pc_next = pc_imm;
                            if (!addr_ok) err = STS_LOAD_FAULT;
                            if (sp_full) begin
                                if (err == STS_OK) err = STS_OVERFLOW;
                            end else begin
                                ds_we = 1'b1; ds_wdata = ld_val;
                                sp_next = sp_reg + SPW'(1); tos_next = ld_val;
                            end
                        end
                        OP_JMP: pc_next = jmp_t;
                        OP_JZ, OP_JNZ: begin
                            if (!sp_ge1) err = STS_UNDERFLOW;
                            sp_next = sp1; tos_next = ds_rdata;
                            if ((b_val == 32'd0) == (op_reg == OP_JZ)) pc_next = jmp_t;
                            else pc_next = pc_imm;
                        end
                        OP_CALL: begin
                            if (rp_reg == RPW'(RETURN_STACK_DEPTH)) begin
                                err = STS_CALL_OVF;
                            end else begin
                                rs_we = 1'b1;
                                rp_next = rp_reg + RPW'(1); pc_next = jmp_t;
                            end
                        end
                        OP_RET: begin
                            if (rp_reg == '0) begin
                                err = STS_CALL_UNF;
                            end else begin
                                rp_next = rp_m1; pc_next = rs_rdata;
                            end
                        end
                        default: err = STS_BAD_OP;
                    endcase
                    if (err != STS_OK) run_next = 1'b0;
                    status_next = (err != STS_OK) ? err : (halted ? STS_HALTED : STS_OK);
                end
            end
            ST_DIVW: begin
                if (div_done) begin
                    ds_we = 1'b1; ds_wdata = div_q;
                    sp_next = sp_reg + SPW'(1); tos_next = div_q;
                    state_next = ST_FINISH;
                end
            end
            ST_WR2: begin
                ds_we = 1'b1; ds_wdata = 32'd0;
                sp_next = sp_reg + SPW'(1);
                state_next = ST_FINISH;
            end
            ST_REFILL: begin
                tos_next   = ds_rdata;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, status_reg,
                                     run_reg && (pc32 < clen32),
                                     sp32[8:0], top_out, pc32[15:0]};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (m_tvalid_reg && m_tready && !(state_reg == ST_FINISH && out_free)) begin
            m_tvalid_next = 1'b0;
        end

        if (accept) begin
            op_next    = s_tuser;
            imm_next   = s_tdata;
            state_next = ST_EXEC;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- design/sbe_checker.sv -----
// ----------------------------------------------------------------------------
// sbe_checker
// Port-level checks for the stack bytecode executor, bound to the top level.
// ----------------------------------------------------------------------------
module sbe_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // result held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

    // one instruction at a time: no accept in the cycle after an accept
    a_no_b2b: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("instruction accepted during execute");

    // any non-ok status means the machine has stopped
    a_stop_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[61:58] != 4'd0) |-> !m_tdata[57])
        else $error("running flag set with non-ok status");

    // status code stays within the defined set
    a_status_rng: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[61:58] <= 4'd11) && (m_tdata[63:62] == 2'b00))
        else $error("undefined status code");

endmodule

bind stack_bytecode_executor_top sbe_checker u_sbe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/sbe_result_checker.sv -----
// ----------------------------------------------------------------------------
// sbe_result_checker
// Watches the instruction and result streams of the stack bytecode executor,
// executes every accepted instruction on its own copy of the machine and
// compares each result beat field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module sbe_result_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [sbe_pkg::CLEN_W-1:0]  cfg_wr_data,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [sbe_pkg::WORD_W-1:0]  s_tdata,
    input  logic [sbe_pkg::OP_W-1:0]    s_tuser,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [sbe_pkg::OUT_W-1:0]   m_tdata,
    output int                          fail_count,
    output int                          pending
);
    import sbe_pkg::*;

    typedef struct packed {
        logic [15:0]     npc;
        logic [31:0]     top;
        logic [8:0]      depth;
        logic            running;
        status_t         st;
    } machine_report_t;

    // machine copy, read by the stimulus side as well
    logic [31:0] dstk [DEF_DATA_STACK_DEPTH];
    logic [31:0] wmem [DEF_MEMORY_WORDS];
    bit          word_written [DEF_MEMORY_WORDS];
    logic [15:0] rstk [DEF_RETURN_STACK_DEPTH];
    int unsigned sp;
    int unsigned rp;
    logic [15:0] pc_q;
    bit          run_q;
    logic [15:0] clen_q;
    logic [31:0] tos;
    status_t     fault;

    machine_report_t report_q[$];

    assign pending = report_q.size();
    assign tos     = (sp > 0) ? dstk[sp-1] : 32'd0;

    task automatic raise_fault(input status_t code);
        run_q = 1'b0;
        if (fault == STS_OK) fault = code;
    endtask

    task automatic pop_word(output logic [31:0] v);
        if (sp == 0) begin
            raise_fault(STS_UNDERFLOW);
            v = 32'd0;
        end else begin
            sp--;
            v = dstk[sp];
        end
    endtask

    task automatic push_word(input logic [31:0] v);
        if (sp >= DEF_DATA_STACK_DEPTH) begin
            raise_fault(STS_OVERFLOW);
        end else begin
            dstk[sp] = v;
            sp++;
        end
    endtask

    task automatic execute_instr(input logic [4:0] op, input logic [31:0] imm,
                                 output machine_report_t rpt);
        logic [15:0] nxt;
        logic [15:0] after;
        logic [31:0] a;
        logic [31:0] b;
        bit          halted;
        bit          addr_ok;
        status_t     st;
        fault   = STS_OK;
        halted  = 1'b0;
        addr_ok = !imm[31] && imm < DEF_MEMORY_WORDS;
        if (!run_q) begin
            st = STS_STOPPED;
        end else if (pc_q >= clen_q) begin
            run_q = 1'b0;
            st    = STS_END;
        end else begin
            nxt   = pc_q + 16'd1;
            after = nxt + 16'd4;
            case (op)
                OP_PUSH: begin nxt = after; push_word(imm); end
                OP_POP:  pop_word(a);
                OP_DUP: begin pop_word(a); push_word(a); push_word(a); end
                OP_HALT: begin run_q = 1'b0; halted = 1'b1; end
                OP_ADD: begin pop_word(b); pop_word(a); push_word(a + b); end
                OP_SUB: begin pop_word(b); pop_word(a); push_word(a - b); end
                OP_MUL: begin pop_word(b); pop_word(a); push_word(a * b); end
                OP_DIV: begin
                    pop_word(b); pop_word(a);
                    if (b == 0)
                        raise_fault(STS_DIV_ZERO);
                    else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
                        push_word(32'h8000_0000);   // wraps
                    else
                        push_word($signed(a) / $signed(b));
                end
                OP_CMP: begin
                    pop_word(b); pop_word(a);
                    push_word(($signed(a) < $signed(b)) ? 32'd1 : 32'd0);
                end
                OP_STW: begin
                    nxt = after;
                    pop_word(a);
                    if (addr_ok) begin
                        wmem[imm[9:0]]         = a;
                        word_written[imm[9:0]] = 1'b1;
                    end else begin
                        raise_fault(STS_STORE_FAULT);
                    end
                end
                OP_LOAD: begin
                    nxt = after;
                    if (addr_ok) begin
                        push_word(wmem[imm[9:0]]);
                    end else begin
                        raise_fault(STS_LOAD_FAULT);
                        push_word(32'd0);
                    end
                end
                OP_JMP: nxt = imm[15:0];
                OP_JZ: begin pop_word(a); nxt = (a == 0) ? imm[15:0] : after; end
                OP_JNZ: begin pop_word(a); nxt = (a != 0) ? imm[15:0] : after; end
                OP_CALL: begin
                    if (rp >= DEF_RETURN_STACK_DEPTH) begin
                        raise_fault(STS_CALL_OVF);   // immediate not consumed
                    end else begin
                        rstk[rp] = after;
                        rp++;
                        nxt = imm[15:0];
                    end
                end
                OP_RET: begin
                    if (rp == 0) begin
                        raise_fault(STS_CALL_UNF);
                    end else begin
                        rp--;
                        nxt = rstk[rp];
                    end
                end
                default: raise_fault(STS_BAD_OP);
            endcase
            pc_q = nxt;
            st = (fault != STS_OK) ? fault : (halted ? STS_HALTED : STS_OK);
        end
        rpt.npc     = pc_q;
        rpt.top     = (sp > 0) ? dstk[sp-1] : 32'd0;
        rpt.depth   = sp[8:0];
        rpt.running = run_q && (pc_q < clen_q);
        rpt.st      = st;
    endtask

    always @(posedge aclk) begin
        machine_report_t want;
        machine_report_t got;
        if (!aresetn) begin
            sp         = 0;
            rp         = 0;
            pc_q       = '0;
            run_q      = 1'b1;
            clen_q     = '0;
            fail_count = 0;
            report_q.delete();
            foreach (word_written[i]) word_written[i] = 1'b0;
        end else begin
            if (cfg_wr_en) clen_q = cfg_wr_data;
            if (m_tvalid && m_tready) begin
                got.npc     = m_tdata[15:0];
                got.top     = m_tdata[47:16];
                got.depth   = m_tdata[56:48];
                got.running = m_tdata[57];
                got.st      = status_t'(m_tdata[61:58]);
                if (report_q.size() == 0) begin
                    $error("result beat with no instruction outstanding: %h", m_tdata);
                    fail_count++;
                end else begin
                    want = report_q.pop_front();
                    if (got.npc != want.npc) begin
                        $error("next_pc: expected %h actual %h", want.npc, got.npc);
                        fail_count++;
                    end
                    if (got.top != want.top) begin
                        $error("top_value: expected %h actual %h", want.top, got.top);
                        fail_count++;
                    end
                    if (got.depth != want.depth) begin
                        $error("stack_depth: expected %0d actual %0d",
                               want.depth, got.depth);
                        fail_count++;
                    end
                    if (got.running != want.running) begin
                        $error("still_running: expected %0d actual %0d",
                               want.running, got.running);
                        fail_count++;
                    end
                    if (got.st != want.st) begin
                        $error("status: expected %0d actual %0d", want.st, got.st);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                execute_instr(s_tuser, s_tdata, want);
                report_q.push_back(want);
            end
        end
    end

endmodule

// ----- tb/stack_bytecode_executor_top_tb.sv -----
// ----------------------------------------------------------------------------
// stack_bytecode_executor_top_tb
// Drives instruction beats into the stack bytecode executor and lets the
// checker predict and compare every result. A directed warm-up is followed
// by well-formed random programs over several code lengths and one final
// stopping case, after which the stopped machine is poked six more times.
// ----------------------------------------------------------------------------
module stack_bytecode_executor_top_tb;
    import sbe_pkg::*;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [CLEN_W-1:0]   cfg_wr_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [WORD_W-1:0]   s_tdata;       // [31:0] immediate
    logic [OP_W-1:0]     s_tuser;       // [4:0] operation
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;       // next_pc, top, depth, running, status
    int                  fail_count;
    int                  pending;

    int                  n_sent;
    int                  n_recv;
    int                  n_phases;
    int                  end_kind;

    stack_bytecode_executor_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    sbe_result_checker i_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // hard stop; the slowest legal run is far below this
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // result side: per beat a random stall, with bursts of none
    initial begin
        int stall;
        m_tready = 1'b0;
        n_recv   = 0;
        forever begin
            stall = ((n_recv / 60) % 3 == 0) ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            n_recv++;
        end
    end

    // One instruction beat. Returns once the accept has been clocked, so the
    // checker's machine copy already reflects this instruction.
    task automatic send_instr(input logic [4:0] op, input logic [31:0] imm);
        int gap;
        gap = ((n_sent / 70) % 3 == 1) ? 0 : $urandom_range(0, 17);
        repeat (gap) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= imm;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        s_tvalid <= 1'b0;
        n_sent++;
        @(posedge aclk);
    endtask

    // wait for every outstanding result; sampled away from the clock edge
    task automatic wait_drained();
        do @(negedge aclk); while (pending != 0);
        @(posedge aclk);
    endtask

    task automatic write_code_length(input logic [15:0] len);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
    endtask

    // jump target inside the program, upper bits random (they are dropped)
    function automatic logic [31:0] pick_target();
        logic [15:0] t;
        t = 16'($urandom_range(0, i_chk.clen_q - 8));
        return {16'($urandom()), t};
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0000_0001;
            default: return $urandom();
        endcase
    endfunction

    // one well-formed random instruction: never faults, stays in the program
    task automatic random_instr();
        int          k;
        int          d;
        int          r;
        logic [9:0]  addr;
        d = i_chk.sp;
        r = i_chk.rp;
        k = $urandom_range(0, 99);
        if (i_chk.pc_q + 6 >= i_chk.clen_q)
            send_instr(OP_JMP, pick_target());      // wrap back before the end
        else if (k < 22 && d < 240)
            send_instr(OP_PUSH, pick_value());
        else if (k < 30 && d >= 1)
            send_instr(OP_POP, $urandom());
        else if (k < 36 && d >= 1 && d < 250)
            send_instr(OP_DUP, $urandom());
        else if (k < 44 && d >= 2)
            send_instr(OP_ADD, $urandom());
        else if (k < 50 && d >= 2)
            send_instr(OP_SUB, $urandom());
        else if (k < 56 && d >= 2)
            send_instr(OP_MUL, $urandom());
        else if (k < 62 && d >= 2 && i_chk.tos != 0)
            send_instr(OP_DIV, $urandom());
        else if (k < 68 && d >= 2)
            send_instr(OP_CMP, $urandom());
        else if (k < 74 && d >= 1)
            send_instr(OP_STW, $urandom_range(0, DEF_MEMORY_WORDS - 1));
        else if (k < 80 && d < 250) begin
            addr = 10'($urandom_range(0, DEF_MEMORY_WORDS - 1));
            if (!i_chk.word_written[addr]) addr = '0;   // only written words
            send_instr(OP_LOAD, {22'd0, addr});
        end else if (k < 86)
            send_instr(OP_JMP, pick_target());
        else if (k < 90 && d >= 1)
            send_instr(OP_JZ, pick_target());
        else if (k < 94 && d >= 1)
            send_instr(OP_JNZ, pick_target());
        else if (k < 97 && r < 250)
            send_instr(OP_CALL, pick_target());
        else if (k >= 97 && r >= 1)
            send_instr(OP_RET, $urandom());
        else if (d < 128)
            send_instr(OP_PUSH, pick_value());
        else
            send_instr(OP_POP, $urandom());
    endtask

    // unwind calls and park at pc 0 so a new code length is safe
    task automatic park_machine();
        while (i_chk.rp > 0) send_instr(OP_RET, $urandom());
        send_instr(OP_JMP, 32'd0);
    endtask

    initial begin
        logic [15:0] lens [4];
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        n_sent      = 0;
        n_phases    = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed warm-up at the longest program ----
        write_code_length(16'hFFFF);
        send_instr(OP_PUSH, 32'h7FFF_FFFF);  send_instr(OP_STW, 32'd0);
        send_instr(OP_PUSH, 32'h8000_0000);  send_instr(OP_STW, 32'd1);
        send_instr(OP_PUSH, 32'hFFFF_FFFF);  send_instr(OP_STW, 32'd2);
        send_instr(OP_PUSH, 32'h0000_0000);  send_instr(OP_STW, 32'd1023);
        // most negative / -1 wraps
        send_instr(OP_PUSH, 32'h8000_0000);
        send_instr(OP_PUSH, 32'hFFFF_FFFF);
        send_instr(OP_DIV, 32'd0);
        // pc advance wraps past the top of the pc range
        send_instr(OP_JMP, 32'h0000_FFFE);
        send_instr(OP_PUSH, 32'h7FFF_FFFF);
        send_instr(OP_CMP, 32'd0);
        // negative jump target wraps
        send_instr(OP_JMP, 32'hFFFF_0040);
        send_instr(OP_CALL, 32'd200);
        send_instr(OP_RET, 32'd0);
        send_instr(OP_JZ, 32'd300);          // top is 1: falls through
        send_instr(OP_PUSH, 32'd0);
        send_instr(OP_JNZ, 32'd300);         // top is 0: falls through
        send_instr(OP_LOAD, 32'd1023);
        send_instr(OP_LOAD, 32'd1);
        send_instr(OP_MUL, 32'd0);
        send_instr(OP_POP, 32'd0);
        n_phases++;

        // ---- random programs over rising code lengths ----
        lens = '{16'd64, 16'd1000, 16'd40000, 16'hFFFF};
        foreach (lens[p]) begin
            park_machine();
            write_code_length(lens[p]);      // pauses until all results are in
            n_phases++;
            repeat (385) random_instr();
        end
        park_machine();

        // ---- one final stopping case, then a stopped machine ----
        end_kind = $urandom_range(0, 9);
        case (end_kind)
            0: send_instr(OP_HALT, $urandom());
            1: send_instr(5'($urandom_range(16, 31)), $urandom());
            2: begin
                send_instr(OP_PUSH, 32'd7);
                send_instr(OP_PUSH, 32'd0);
                send_instr(OP_DIV, 32'd0);
            end
            3: begin
                while (i_chk.sp > 0) send_instr(OP_POP, 32'd0);
                send_instr(OP_DUP, 32'd0);   // empty: two zeros, underflow
            end
            4: begin
                while (i_chk.sp < DEF_DATA_STACK_DEPTH) send_instr(OP_PUSH, $urandom());
                send_instr(OP_PUSH, $urandom());
            end
            5: send_instr(OP_LOAD, $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1024);
            6: begin
                send_instr(OP_PUSH, $urandom());
                send_instr(OP_STW, $urandom_range(0, 1) ? 32'h8000_0000 : 32'd4000);
            end
            7: send_instr(OP_RET, 32'd0);
            8: begin
                while (i_chk.rp < DEF_RETURN_STACK_DEPTH) send_instr(OP_CALL, 32'd16);
                send_instr(OP_CALL, 32'd16);
            end
            default: begin
                write_code_length(16'd0);    // pc 0 is already past the end
                send_instr(OP_PUSH, $urandom());
            end
        endcase
        repeat (6) send_instr(5'($urandom_range(0, 31)), $urandom());

        wait_drained();
        repeat (40) @(posedge aclk);
        $display("Ran %0d instructions over %0d code length settings", n_sent, n_phases);
        $display("Final stopping case %0d, then stopped-machine beats", end_kind);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
